// ----- design/ecam_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ECAM region lookup package
// Shared sizes, request codes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package ecam_pkg;

   localparam int MAX_REGIONS = 16;
   localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
   localparam int BUS_SHIFT   = 20;

   localparam int ADDR_W      = 64;
   localparam int SEG_W       = 16;
   localparam int BUS_W       = 8;
   localparam int OP_W        = 2;
   localparam int ENTRY_CNT_W = 5;

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [SEG_W-1:0]  segment;
      logic [BUS_W-1:0]  first_bus;
      logic [BUS_W-1:0]  last_bus;
   } region_type;

   typedef struct packed {
      logic capture;      // latch the request fields, rewind the scan
      logic apply;        // perform clear or load and post a result
      logic scan;         // issue the next table read
      logic finish_hit;   // post the matching entry's address
      logic finish_miss;  // post a miss
   } cmd_type;

   typedef struct packed {
      logic is_lookup;
      logic match;
      logic exhausted;
   } status_type;

endpackage
`default_nettype wire

// ----- design/ecam_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ECAM region lookup controller
// Sequences one request: capture, then either apply a clear or load, or scan
// the region table until a match or the end of the held entries.
// ----------------------------------------------------------------------------
module ecam_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  ecam_pkg::status_type     status,
   output ecam_pkg::cmd_type        cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.is_lookup) begin
               state_in = ST_SCAN;
            end else begin
               cmd.apply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // the read issued here is dropped when the entry in hand matches
            cmd.scan = 1'b1;
            if (status.match) begin
               cmd.finish_hit = 1'b1;
               state_in       = ST_IDLE;
            end else if (status.exhausted) begin
               cmd.finish_miss = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_enters_exec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_EXEC))
      else $error("accepted request did not enter execute");

   a_finish_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.finish_hit && cmd.finish_miss))
      else $error("hit and miss posted together");

   a_non_lookup_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && !status.is_lookup) |=> (state_ff == ST_IDLE))
      else $error("clear or load did not finish in one cycle");

endmodule
`default_nettype wire

// ----- design/ecam_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ECAM region lookup datapath
// Request registers, region table memory, held count, scan pointer with a
// registered read stage, match logic and the result registers.
// ----------------------------------------------------------------------------
module ecam_dpath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  ecam_pkg::cmd_type                          cmd,
   output ecam_pkg::status_type                       status,
   input  wire logic [ecam_pkg::OP_W-1:0]             req_op,
   input  wire logic [ecam_pkg::ADDR_W-1:0]           req_region_base,
   input  wire logic [ecam_pkg::SEG_W-1:0]            req_region_segment,
   input  wire logic [ecam_pkg::BUS_W-1:0]            req_region_first_bus,
   input  wire logic [ecam_pkg::BUS_W-1:0]            req_region_last_bus,
   input  wire logic [ecam_pkg::SEG_W-1:0]            req_query_segment,
   input  wire logic [ecam_pkg::BUS_W-1:0]            req_query_bus,
   output logic                                       rsp_strobe,
   output logic [ecam_pkg::ADDR_W-1:0]                rsp_config_address,
   output logic                                       rsp_hit,
   output logic [ecam_pkg::ENTRY_CNT_W-1:0]           rsp_entry_count
);

   // request registers
   logic [ecam_pkg::OP_W-1:0]   op_ff;
   ecam_pkg::region_type        load_ff;
   logic [ecam_pkg::SEG_W-1:0]  qseg_ff;
   logic [ecam_pkg::BUS_W-1:0]  qbus_ff;

   // table state
   ecam_pkg::region_type        table_mem [ecam_pkg::MAX_REGIONS];
   logic [ecam_pkg::CNT_W-1:0]  count_ff;
   logic [ecam_pkg::CNT_W-1:0]  count_in;
   logic                        table_full;
   logic                        do_write;

   // scan
   logic [ecam_pkg::CNT_W-1:0]  scan_idx_ff;
   logic                        issue;
   ecam_pkg::region_type        rd_ff;
   logic                        rd_valid_ff;
   logic                        entry_match;
   logic [ecam_pkg::BUS_W-1:0]  bus_diff;
   logic [ecam_pkg::ADDR_W-1:0] hit_addr;

   // result
   logic                        rsp_valid_ff;
   logic                        rsp_hit_ff;
   logic [ecam_pkg::ADDR_W-1:0] rsp_addr_ff;

   assign table_full = (count_ff >= ecam_pkg::CNT_W'(ecam_pkg::MAX_REGIONS));
   assign do_write   = cmd.apply && (op_ff == ecam_pkg::OP_LOAD) && !table_full;
   assign issue      = cmd.scan && (scan_idx_ff < count_ff);

   always_comb begin
      count_in = count_ff;
      if (cmd.apply) begin
         priority if (op_ff == ecam_pkg::OP_CLEAR) begin
            count_in = '0;
         end else if (do_write) begin
            count_in = count_ff + ecam_pkg::CNT_W'(1);
         end
      end
   end

   assign entry_match = (rd_ff.segment == qseg_ff) &&
                        (qbus_ff >= rd_ff.first_bus) &&
                        (qbus_ff <= rd_ff.last_bus);
   assign bus_diff    = qbus_ff - rd_ff.first_bus;
   assign hit_addr    = rd_ff.base + (ecam_pkg::ADDR_W'(bus_diff) << ecam_pkg::BUS_SHIFT);

   assign status.is_lookup = (op_ff == ecam_pkg::OP_LOOKUP);
   assign status.match     = rd_valid_ff && entry_match;
   assign status.exhausted = !rd_valid_ff && (scan_idx_ff >= count_ff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff             <= req_op;
         load_ff.base      <= req_region_base;
         load_ff.segment   <= req_region_segment;
         load_ff.first_bus <= req_region_first_bus;
         load_ff.last_bus  <= req_region_last_bus;
         qseg_ff           <= req_query_segment;
         qbus_ff           <= req_query_bus;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         table_mem[count_ff[ecam_pkg::IDX_W-1:0]] <= load_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_ff <= table_mem[scan_idx_ff[ecam_pkg::IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.apply || cmd.finish_hit || cmd.finish_miss;
         if (cmd.capture) begin
            scan_idx_ff <= '0;
            rd_valid_ff <= 1'b0;
         end else begin
            // drop any read still in flight once the result is posted
            rd_valid_ff <= issue && !cmd.finish_hit;
            if (issue) begin
               scan_idx_ff <= scan_idx_ff + ecam_pkg::CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply || cmd.finish_hit || cmd.finish_miss) begin
         rsp_hit_ff  <= cmd.finish_hit;
         rsp_addr_ff <= cmd.finish_hit ? hit_addr : '0;
      end
   end

   assign rsp_strobe         = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_config_address = rsp_addr_ff;
   assign rsp_entry_count    = ecam_pkg::ENTRY_CNT_W'(count_ff);

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ecam_pkg::CNT_W'(ecam_pkg::MAX_REGIONS))
      else $error("held count beyond table depth");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |-> (rsp_addr_ff == '0))
      else $error("miss result carries an address");

   a_hit_is_lookup: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hit_ff) |-> (op_ff == ecam_pkg::OP_LOOKUP))
      else $error("hit reported for a non-lookup request");

   a_match_within_held: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (scan_idx_ff <= count_ff) && (scan_idx_ff != '0))
      else $error("table read outside held entries");

endmodule
`default_nettype wire

// ----- design/ecam_region_lookup.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ECAM region lookup
// Table of up to MAX_REGIONS configuration regions with clear, load and
// first-match lookup of a segment and bus into a configuration address.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start / busy         req_op, req_region_*, req_query_*
//  result    rsp_strobe (1 cycle) rsp_config_address, rsp_hit, rsp_entry_count
//
//  Clear, load and unused codes: capture, then apply in the execute state;
//  the result strobes from the result registers. Lookup: one table read
//  per cycle from a registered memory port; a miss strobes after every held
//  entry is read without a match, a hit after the read of its entry.
//  busy drops as the result strobes; a new request may be taken that cycle.
//  Synchronous reset empties the table; no clearing pass is needed.
//  The receiver cannot stall: each result is present for one cycle only.
// ----------------------------------------------------------------------------
module ecam_region_lookup (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [ecam_pkg::OP_W-1:0]             req_op,
   input  wire logic [ecam_pkg::ADDR_W-1:0]           req_region_base,
   input  wire logic [ecam_pkg::SEG_W-1:0]            req_region_segment,
   input  wire logic [ecam_pkg::BUS_W-1:0]            req_region_first_bus,
   input  wire logic [ecam_pkg::BUS_W-1:0]            req_region_last_bus,
   input  wire logic [ecam_pkg::SEG_W-1:0]            req_query_segment,
   input  wire logic [ecam_pkg::BUS_W-1:0]            req_query_bus,
   output logic                                       rsp_strobe,
   output logic [ecam_pkg::ADDR_W-1:0]                rsp_config_address,
   output logic                                       rsp_hit,
   output logic [ecam_pkg::ENTRY_CNT_W-1:0]           rsp_entry_count
);

   ecam_pkg::cmd_type    cmd;
   ecam_pkg::status_type status;

   ecam_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   ecam_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_op               (req_op),
      .req_region_base      (req_region_base),
      .req_region_segment   (req_region_segment),
      .req_region_first_bus (req_region_first_bus),
      .req_region_last_bus  (req_region_last_bus),
      .req_query_segment    (req_query_segment),
      .req_query_bus        (req_query_bus),
      .rsp_strobe           (rsp_strobe),
      .rsp_config_address   (rsp_config_address),
      .rsp_hit              (rsp_hit),
      .rsp_entry_count      (rsp_entry_count)
   );

endmodule
`default_nettype wire
